>>> rtl/video_pixel_unpacker_unit_defines.svh
// Assertion macros for the video pixel unpacker.
// Included by the top level; expects aclk and aresetn in scope.
`ifndef VIDEO_PIXEL_UNPACKER_UNIT_DEFINES_SVH
`define VIDEO_PIXEL_UNPACKER_UNIT_DEFINES_SVH

// Checks that a condition holds at every clock edge outside reset.
`define VPU_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (cond)) else $error(msg);

// Checks that the consequent holds whenever the antecedent holds.
`define VPU_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define VPU_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/vpu_pkg.sv
// Package for the video pixel unpacker: pixel format codes, register
// addresses and field widths. No dependencies.
`default_nettype none

package vpu_pkg;

    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned CHAN_W  = 8;
    localparam int unsigned PIXEL_W = 3 * CHAN_W;
    localparam int unsigned ADDR_W  = 3;
    localparam int unsigned APB_W   = 32;

    typedef enum logic [1:0] {
        FMT_GREY   = 2'd0,
        FMT_RGB565 = 2'd1,
        FMT_RGB555 = 2'd2,
        FMT_RGB24  = 2'd3
    } pixel_format_t;

    // Register select bit of paddr: 0 selects pixel_format, 1 selects grey_wide.
    localparam int unsigned REG_SEL_BIT = 2;

    typedef enum logic {
        REG_PIXEL_FORMAT = 1'b0,
        REG_GREY_WIDE    = 1'b1
    } reg_index_t;

    localparam pixel_format_t FORMAT_RESET    = FMT_RGB24;
    localparam logic          GREY_WIDE_RESET = 1'b1;

endpackage

`default_nettype wire

>>> rtl/video_pixel_unpacker_unit.sv
// Video pixel unpacker: assembles camera bytes into 8-bit RGB pixels.
// A pixel's last byte passes the input register, then the result registers.
// Throughput: one byte beat per cycle; the input register keeps taking
// bytes while a result beat waits on m_tready, until both stages are full.
// Reset (aresetn low, synchronous): format RGB24, grey_wide set, no partial
// pixel held, both stages empty. Depends on vpu_pkg and the defines header.
`default_nettype none

`include "video_pixel_unpacker_unit_defines.svh"

module video_pixel_unpacker_unit (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    // Input stream.
    input  wire logic                       s_tvalid,
    output      logic                       s_tready,
    input  wire logic [vpu_pkg::BYTE_W-1:0] s_tdata,   // [7:0] byte_value
    // Result stream.
    output      logic                       m_tvalid,
    input  wire logic                       m_tready,
    output      logic [vpu_pkg::PIXEL_W-1:0] m_tdata,  // [7:0] red, [15:8] green,
                                                       // [23:16] blue
    // Configuration port.
    input  wire logic                       psel,
    input  wire logic                       penable,
    input  wire logic                       pwrite,
    input  wire logic [vpu_pkg::ADDR_W-1:0] paddr,
    input  wire logic [vpu_pkg::APB_W-1:0]  pwdata,
    output      logic [vpu_pkg::APB_W-1:0]  prdata,
    output      logic                       pready
);
    import vpu_pkg::*;

    pixel_format_t       format_reg;
    logic                grey_wide_reg;
    logic [1:0]          bytes_held_reg, bytes_held_next;
    logic [BYTE_W-1:0]   first_byte_reg, second_byte_reg;
    logic                in_valid_reg;
    logic [BYTE_W-1:0]   in_byte_reg;
    logic                out_valid_reg;
    logic [CHAN_W-1:0]   red_reg, green_reg, blue_reg;
    logic [CHAN_W-1:0]   red_next, green_next, blue_next;

    logic                cfg_write;
    reg_index_t          cfg_sel;
    logic [1:0]          need;
    logic                complete;
    logic                out_free;
    logic                consume;

    assign pready    = 1'b1;
    assign cfg_sel   = reg_index_t'(paddr[REG_SEL_BIT]);
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb begin
        prdata = '0;
        case (cfg_sel)
            REG_PIXEL_FORMAT: prdata[1:0] = format_reg;
            REG_GREY_WIDE:    prdata[0]   = grey_wide_reg;
            default:          prdata      = '0;
        endcase
    end

    always_comb begin
        case (format_reg)
            FMT_GREY:   need = grey_wide_reg ? 2'd2 : 2'd1;
            FMT_RGB565: need = 2'd2;
            FMT_RGB555: need = 2'd2;
            FMT_RGB24:  need = 2'd3;
            default:    need = 2'd3;
        endcase
    end

    assign complete = ({1'b0, bytes_held_reg} + 3'd1) >= {1'b0, need};
    assign out_free = !out_valid_reg || m_tready;
    assign consume  = in_valid_reg && (!complete || out_free);
    assign s_tready = !in_valid_reg || consume;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {blue_reg, green_reg, red_reg};

    always_comb begin
        red_next   = in_byte_reg;
        green_next = in_byte_reg;
        blue_next  = in_byte_reg;
        case (format_reg)
            FMT_GREY: begin
                red_next   = in_byte_reg;
                green_next = in_byte_reg;
                blue_next  = in_byte_reg;
            end
            FMT_RGB565: begin
                red_next   = {in_byte_reg[7:3], 3'b000};
                green_next = {in_byte_reg[2:0], first_byte_reg[7:5], 2'b00};
                blue_next  = {first_byte_reg[4:0], 3'b000};
            end
            FMT_RGB555: begin
                red_next   = {first_byte_reg[7:3], 3'b000};
                green_next = {first_byte_reg[2:0], in_byte_reg[7:6], 3'b000};
                blue_next  = {in_byte_reg[5:1], 3'b000};
            end
            FMT_RGB24: begin
                red_next   = first_byte_reg;
                green_next = second_byte_reg;
                blue_next  = in_byte_reg;
            end
            default: begin
                red_next   = in_byte_reg;
                green_next = in_byte_reg;
                blue_next  = in_byte_reg;
            end
        endcase
    end

    always_comb begin
        bytes_held_next = bytes_held_reg;
        if (cfg_write) begin
            bytes_held_next = 2'd0;
        end else if (consume) begin
            bytes_held_next = complete ? 2'd0 : bytes_held_reg + 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            format_reg     <= FORMAT_RESET;
            grey_wide_reg  <= GREY_WIDE_RESET;
            bytes_held_reg <= 2'd0;
            in_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            bytes_held_reg <= bytes_held_next;
            if (cfg_write) begin
                case (cfg_sel)
                    REG_PIXEL_FORMAT: format_reg    <= pixel_format_t'(pwdata[1:0]);
                    REG_GREY_WIDE:    grey_wide_reg <= pwdata[0];
                    default:          grey_wide_reg <= grey_wide_reg;
                endcase
            end
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end
            if (consume && complete) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_byte_reg <= s_tdata;
        end
        if (consume && !complete) begin
            if (bytes_held_reg == 2'd0) begin
                first_byte_reg <= in_byte_reg;
            end else begin
                second_byte_reg <= in_byte_reg;
            end
        end
        if (consume && complete) begin
            red_reg   <= red_next;
            green_reg <= green_next;
            blue_reg  <= blue_next;
        end
    end

    `VPU_ASSERT_ALWAYS(a_held_below_need, bytes_held_reg < need,
        "Partial pixel count reached the pixel size.")
    `VPU_ASSERT_NEXT(a_complete_gives_beat, consume && complete, m_tvalid,
        "A completed pixel produced no result beat.")
    `VPU_ASSERT_IMPL(a_grey_equal, m_tvalid && format_reg == FMT_GREY,
        m_tdata[7:0] == m_tdata[15:8] && m_tdata[15:8] == m_tdata[23:16],
        "Grey pixel has unequal channels.")
    `VPU_ASSERT_IMPL(a_narrow_low_bits,
        m_tvalid && (format_reg == FMT_RGB565 || format_reg == FMT_RGB555),
        m_tdata[2:0] == 3'b000 && m_tdata[18:16] == 3'b000,
        "Narrow channel low bits are not zero.")

endmodule

`default_nettype wire

>>> tb/sv/video_pixel_unpacker_checker.sv
// Checker for the video pixel unpacker: watches the byte, pixel and register
// channels, predicts each pixel and compares it with the beat that comes out.
// Depends on vpu_pkg.
`default_nettype none

module video_pixel_unpacker_checker (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        s_tvalid,
    input  wire logic                        s_tready,
    input  wire logic [vpu_pkg::BYTE_W-1:0]  s_tdata,   // [7:0] byte_value
    input  wire logic                        m_tvalid,
    input  wire logic                        m_tready,
    input  wire logic [vpu_pkg::PIXEL_W-1:0] m_tdata,   // [7:0] red, [15:8] green,
                                                        // [23:16] blue
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [vpu_pkg::ADDR_W-1:0]  paddr,
    input  wire logic [vpu_pkg::APB_W-1:0]   pwdata,
    input  wire logic [vpu_pkg::APB_W-1:0]   prdata,
    input  wire logic                        pready,
    output int unsigned                      fail_count,
    output int unsigned                      pending
);
    import vpu_pkg::*;

    typedef struct packed {
        logic [CHAN_W-1:0] blue;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] red;
    } rgb_pixel_t;

    rgb_pixel_t    pixel_q[$];
    pixel_format_t cur_format;
    logic          cur_grey_wide;
    logic [1:0]    bytes_held;
    logic [7:0]    held_byte0;
    logic [7:0]    held_byte1;
    int unsigned   errors;

    function automatic int unsigned bytes_per_pixel(pixel_format_t fmt, logic wide);
        case (fmt)
            FMT_GREY:               return wide ? 2 : 1;
            FMT_RGB565, FMT_RGB555: return 2;
            default:                return 3;
        endcase
    endfunction

    function automatic rgb_pixel_t decode_pixel(pixel_format_t fmt, logic [7:0] b0,
                                                logic [7:0] b1, logic [7:0] last);
        logic [15:0] word;
        logic [15:0] mix;
        rgb_pixel_t  px;
        word = {last, b0};
        mix  = ({8'h00, b0} << 5) | ({8'h00, last} >> 3);
        case (fmt)
            FMT_GREY: begin
                px.red   = last;
                px.green = last;
                px.blue  = last;
            end
            FMT_RGB565: begin
                px.red   = {word[15:11], 3'b000};
                px.green = {word[10:5], 2'b00};
                px.blue  = {word[4:0], 3'b000};
            end
            FMT_RGB555: begin
                px.red   = b0 & 8'hF8;
                px.green = mix[7:0] & 8'hF8;
                px.blue  = {last[5:0], 2'b00} & 8'hF8;
            end
            default: begin
                px.red   = b0;
                px.green = b1;
                px.blue  = last;
            end
        endcase
        return px;
    endfunction

    initial begin
        errors     = 0;
        fail_count = 0;
        pending    = 0;
    end

    always @(posedge aclk) begin
        rgb_pixel_t got;
        rgb_pixel_t want;
        if (!aresetn) begin
            cur_format    = FORMAT_RESET;
            cur_grey_wide = GREY_WIDE_RESET;
            bytes_held    = 2'd0;
            held_byte0    = 8'h00;
            held_byte1    = 8'h00;
            pixel_q.delete();
        end else begin
            if (psel && penable && pready && pwrite) begin
                if (paddr == ADDR_W'(int'(REG_PIXEL_FORMAT) << REG_SEL_BIT)) begin
                    cur_format = pixel_format_t'(pwdata[1:0]);
                    bytes_held = 2'd0;
                end else if (paddr == ADDR_W'(int'(REG_GREY_WIDE) << REG_SEL_BIT)) begin
                    cur_grey_wide = pwdata[0];
                    bytes_held    = 2'd0;
                end
            end
            if (psel && penable && pready && !pwrite) begin
                if (paddr == ADDR_W'(int'(REG_PIXEL_FORMAT) << REG_SEL_BIT) &&
                    prdata != APB_W'(cur_format)) begin
                    $display("%0t: pixel_format read expected %08h, got %08h",
                             $time, APB_W'(cur_format), prdata);
                    errors++;
                end
                if (paddr == ADDR_W'(int'(REG_GREY_WIDE) << REG_SEL_BIT) &&
                    prdata != APB_W'(cur_grey_wide)) begin
                    $display("%0t: grey_wide read expected %08h, got %08h",
                             $time, APB_W'(cur_grey_wide), prdata);
                    errors++;
                end
            end
            if (s_tvalid && s_tready) begin
                if (int'(bytes_held) + 1 < bytes_per_pixel(cur_format, cur_grey_wide)) begin
                    if (bytes_held == 2'd0)
                        held_byte0 = s_tdata;
                    else
                        held_byte1 = s_tdata;
                    bytes_held = bytes_held + 2'd1;
                end else begin
                    pixel_q.push_back(decode_pixel(cur_format, held_byte0, held_byte1,
                                                   s_tdata));
                    bytes_held = 2'd0;
                end
            end
            if (m_tvalid && m_tready) begin
                got = m_tdata;
                if (pixel_q.size() == 0) begin
                    $display("%0t: unexpected pixel beat, expected none, got %06h",
                             $time, m_tdata);
                    errors++;
                end else begin
                    want = pixel_q.pop_front();
                    if (got.red != want.red) begin
                        $display("%0t: red expected %02h, got %02h",
                                 $time, want.red, got.red);
                        errors++;
                    end
                    if (got.green != want.green) begin
                        $display("%0t: green expected %02h, got %02h",
                                 $time, want.green, got.green);
                        errors++;
                    end
                    if (got.blue != want.blue) begin
                        $display("%0t: blue expected %02h, got %02h",
                                 $time, want.blue, got.blue);
                        errors++;
                    end
                end
            end
        end
        pending    <= pixel_q.size();
        fail_count <= errors;
    end

endmodule

`default_nettype wire

>>> tb/sv/video_pixel_unpacker_unit_tb.sv
// Top of the video pixel unpacker testbench: drives bytes and register
// writes with random gaps and stalls, and gives the verdict from the checker.
// Depends on vpu_pkg, video_pixel_unpacker_unit and the checker module.
`default_nettype none

module video_pixel_unpacker_unit_tb;
    import vpu_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 300000;

    logic               aclk;
    logic               aresetn;
    logic               s_tvalid;
    logic               s_tready;
    logic [BYTE_W-1:0]  s_tdata;
    logic               m_tvalid;
    logic               m_tready;
    logic [PIXEL_W-1:0] m_tdata;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [ADDR_W-1:0]  paddr;
    logic [APB_W-1:0]   pwdata;
    logic [APB_W-1:0]   prdata;
    logic               pready;
    int unsigned        fail_count;
    int unsigned        pending;
    int unsigned        cycles;
    bit                 byte_calm;
    bit                 pixel_calm;

    video_pixel_unpacker_unit uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    video_pixel_unpacker_checker checker_i (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial aclk = 1'b0;
    always #1 aclk = ~aclk;

    initial cycles = 0;
    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    task automatic send_byte(logic [7:0] value);
        int unsigned gap;
        gap = byte_calm ? 0 : ($urandom_range(0, 1) == 0 ? 0 : $urandom_range(0, 15));
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= value;
        do @(posedge aclk); while (!s_tready);
    endtask

    // Lowers the byte stream, drains all pending pixels and lets the pipeline empty.
    task automatic settle();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (6) @(posedge aclk);
    endtask

    // Writes one register, then reads it back in the following transfer.
    task automatic write_reg(reg_index_t idx, logic [APB_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_W'(int'(idx) << REG_SEL_BIT);
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
    endtask

    initial begin
        int unsigned stall;
        int unsigned beats;
        m_tready <= 1'b0;
        beats = 0;
        pixel_calm = 1'b0;
        @(posedge aclk);
        forever begin
            if (beats % 30 == 0)
                pixel_calm = ($urandom_range(0, 3) == 0);
            beats++;
            stall = pixel_calm ? 0 : ($urandom_range(0, 1) == 0 ? 0 : $urandom_range(0, 15));
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
        end
    end

    initial begin
        pixel_format_t fmt;
        logic          wide;
        int unsigned   count;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        psel      <= 1'b0;
        penable   <= 1'b0;
        pwrite    <= 1'b0;
        paddr     <= '0;
        pwdata    <= '0;
        aresetn   <= 1'b0;
        byte_calm  = 1'b0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Reset format is RGB24: extremes, then a partial pixel dropped by a write.
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(8'h80);
        send_byte(8'h01);
        settle();
        write_reg(REG_PIXEL_FORMAT, 32'hFFFF_FFFC);
        write_reg(REG_GREY_WIDE, 32'hFFFF_FFFE);
        send_byte(8'h00);
        send_byte(8'hFF);
        settle();
        write_reg(REG_GREY_WIDE, 32'h0000_0001);
        send_byte(8'h12);
        send_byte(8'h34);
        send_byte(8'hFF);
        send_byte(8'hFF);
        settle();
        write_reg(REG_PIXEL_FORMAT, 32'hFFFF_FFF1);
        send_byte(8'hFF);
        send_byte(8'hFF);
        send_byte(8'h1F);
        send_byte(8'hF8);
        send_byte(8'hE0);
        send_byte(8'h07);
        settle();
        write_reg(REG_PIXEL_FORMAT, 32'h8000_0002);
        send_byte(8'h55);
        send_byte(8'hAA);
        send_byte(8'hFF);
        send_byte(8'hFF);
        send_byte(8'h07);
        settle();
        write_reg(REG_PIXEL_FORMAT, 32'h0000_0002);
        send_byte(8'hC0);
        send_byte(8'h3E);

        for (int phase = 0; phase < 12; phase++) begin
            settle();
            fmt  = (phase < 8) ? pixel_format_t'(phase[1:0])
                               : pixel_format_t'($urandom_range(0, 3));
            wide = (phase < 8) ? phase[2] : 1'($urandom_range(0, 1));
            if ($urandom_range(0, 1) == 0) begin
                write_reg(REG_PIXEL_FORMAT, ($urandom & ~32'h3) | APB_W'(fmt));
                write_reg(REG_GREY_WIDE, ($urandom & ~32'h1) | APB_W'(wide));
            end else begin
                write_reg(REG_GREY_WIDE, ($urandom & ~32'h1) | APB_W'(wide));
                write_reg(REG_PIXEL_FORMAT, ($urandom & ~32'h3) | APB_W'(fmt));
            end
            byte_calm = ($urandom_range(0, 3) == 0);
            count = $urandom_range(60, 90);
            for (int i = 0; i < count; i++) begin
                if (i % 25 == 24)
                    byte_calm = ($urandom_range(0, 2) == 0);
                send_byte(8'($urandom_range(0, 255)));
            end
        end

        settle();
        if (fail_count == 0 && pending == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

`default_nettype wire

>>> filelist.f
+incdir+rtl
rtl/vpu_pkg.sv
rtl/video_pixel_unpacker_unit.sv
tb/sv/video_pixel_unpacker_checker.sv
tb/sv/video_pixel_unpacker_unit_tb.sv
